@@ rtl/fixed_point_mul_div_unit_defines.svh @@
// Assertion macros for the checker file of the fixed-point multiply/divide unit
`ifndef FIXED_POINT_MUL_DIV_UNIT_DEFINES_SVH
`define FIXED_POINT_MUL_DIV_UNIT_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define FPMD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpmd: same-cycle check failed");

// next-cycle implication, ignored while in reset
`define FPMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpmd: next-cycle check failed");

`endif

@@ rtl/fpmd_pkg.sv @@
// Types, constants and helpers for the fixed-point multiply/divide unit
package fpmd_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int FIELD_BITS = 32;

  // operands are taken from at most 32 bits of their fields
  localparam int OP_BITS    = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int PROD_BITS  = 2 * OP_BITS;
  localparam int QUO_BITS   = OP_BITS + FRAC_BITS;
  localparam int DIV_BPS    = 2;
  localparam int DIV_STAGES = (QUO_BITS + DIV_BPS - 1) / DIV_BPS;
  localparam int DVD_BITS   = DIV_STAGES * DIV_BPS;

  typedef enum logic {
    CMD_MUL = 1'b0,
    CMD_DIV = 1'b1
  } cmd_t;

  typedef logic signed [FIELD_BITS-1:0] field_t;
  typedef logic        [OP_BITS-1:0]    op_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic        [DVD_BITS-1:0]   dvd_t;

  // one pipeline slot: dividend shifts out at the top, quotient shifts in at the bottom
  typedef struct packed {
    logic   valid;
    cmd_t   cmd;
    logic   dz;
    logic   neg;
    field_t mul_res;
    op_t    divisor;
    op_t    rem;
    dvd_t   dvd;
  } div_stage_t;

  typedef struct packed {
    field_t result_value;
    logic   divide_by_zero;
  } out_item_t;

  // wrap to the word width, then take the low bits of the result field
  function automatic field_t wrap_field(input logic signed [63:0] v);
    logic signed [63:0] w;
    w = 64'(signed'(v[WORD_BITS-1:0]));
    return w[FIELD_BITS-1:0];
  endfunction

endpackage

@@ rtl/fpmd_in_if.sv @@
// Request channel carrying command and operands
interface fpmd_in_if;
  import fpmd_pkg::*;

  logic   valid;
  logic   ready;
  cmd_t   command;
  field_t operand_a;
  field_t operand_b;

  modport source (output valid, command, operand_a, operand_b, input ready);
  modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

@@ rtl/fpmd_out_if.sv @@
// Result channel carrying the product or quotient and the zero-divisor flag
interface fpmd_out_if;
  import fpmd_pkg::*;

  logic   valid;
  logic   ready;
  field_t result_value;
  logic   divide_by_zero;

  modport source (output valid, result_value, divide_by_zero, input ready);
  modport sink   (input valid, result_value, divide_by_zero, output ready);
endinterface

@@ rtl/fpmd_prep.sv @@
// Entry stage: operand extension, signed multiply and divider setup
module fpmd_prep (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  fpmd_pkg::cmd_t      in_command,
  input  fpmd_pkg::field_t    in_operand_a,
  input  fpmd_pkg::field_t    in_operand_b,
  output fpmd_pkg::div_stage_t s_out
);
  import fpmd_pkg::*;

  div_stage_t s_r, s_nxt;

  op_t                       a_u, b_u, ma, mb;
  logic signed [OP_BITS-1:0] sa, sb;
  prod_t                     prod;
  logic signed [63:0]        p64, sh;

  always_comb begin
    a_u  = in_operand_a[OP_BITS-1:0];
    b_u  = in_operand_b[OP_BITS-1:0];
    sa   = signed'(a_u);
    sb   = signed'(b_u);
    prod = prod_t'(sa) * prod_t'(sb);
    p64  = 64'(prod);
    sh   = p64 >>> FRAC_BITS;

    ma = a_u[OP_BITS-1] ? (~a_u + op_t'(1)) : a_u;
    mb = b_u[OP_BITS-1] ? (~b_u + op_t'(1)) : b_u;

    s_nxt.valid   = in_valid;
    s_nxt.cmd     = in_command;
    s_nxt.dz      = (in_command == CMD_DIV) && (b_u == '0);
    s_nxt.neg     = a_u[OP_BITS-1] ^ b_u[OP_BITS-1];
    s_nxt.mul_res = wrap_field(sh);
    s_nxt.divisor = mb;
    s_nxt.rem     = '0;
    s_nxt.dvd     = dvd_t'(ma) << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.valid <= 1'b0;
    end else if (en) begin
      s_r <= s_nxt;
    end
  end

  assign s_out = s_r;

endmodule

@@ rtl/fpmd_div_stage.sv @@
// One divider stage: restoring division, two quotient bits per cycle while en is high
module fpmd_div_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  fpmd_pkg::div_stage_t s_in,
  output fpmd_pkg::div_stage_t s_out
);
  import fpmd_pkg::*;

  div_stage_t s_r, s_nxt;

  always_comb begin
    logic [OP_BITS:0] rem_w;
    op_t              rem;
    dvd_t             dvd;

    rem = s_in.rem;
    dvd = s_in.dvd;
    for (int i = 0; i < DIV_BPS; i++) begin
      rem_w = {rem, dvd[DVD_BITS-1]};
      dvd   = {dvd[DVD_BITS-2:0], 1'b0};
      if (rem_w >= {1'b0, s_in.divisor}) begin
        rem    = OP_BITS'(rem_w - {1'b0, s_in.divisor});
        dvd[0] = 1'b1;
      end else begin
        rem = rem_w[OP_BITS-1:0];
      end
    end

    s_nxt     = s_in;
    s_nxt.rem = rem;
    s_nxt.dvd = dvd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.valid <= 1'b0;
    end else if (en) begin
      s_r <= s_nxt;
    end
  end

  assign s_out = s_r;

endmodule

@@ rtl/fpmd_out_stage.sv @@
// Result select, sign fix-up and output register with skid entry
module fpmd_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fpmd_pkg::div_stage_t s_in,
  output logic                 en,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fpmd_pkg::out_item_t  out_item
);
  import fpmd_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  out_item_t skid_data_r, skid_data_nxt;
  out_item_t res;
  logic [63:0] q64, sq;
  logic        take;

  always_comb begin
    q64 = 64'(s_in.dvd);
    sq  = s_in.neg ? (~q64 + 64'd1) : q64;
    if (s_in.dz) begin
      res.result_value = '0;
    end else if (s_in.cmd == CMD_DIV) begin
      res.result_value = wrap_field(signed'(sq));
    end else begin
      res.result_value = s_in.mul_res;
    end
    res.divide_by_zero = s_in.dz;
  end

  assign take = out_valid_r && out_ready;
  assign en   = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      // pipeline is frozen; drain the skid entry first
      if (take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (s_in.valid) begin
      if (!out_valid_r || take) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_data_r;

endmodule

@@ rtl/fixed_point_mul_div_unit.sv @@
// Top level of the pipelined fixed-point multiply/divide unit
//
//   channel  | direction | payload
//   ---------+-----------+--------------------------------------
//   in_ch    | sink      | command, operand_a, operand_b
//   out_ch   | source    | result_value, divide_by_zero
//
// One request accepted per cycle while in_ch.ready is high, one result per
// request, in order. Each result passes the entry register, the divider stages
// at two quotient bits per stage, and the output register.
// Synchronous active-low reset clears all valid bits; no results pend after it.
// A stalled result parks in a skid entry; in_ch.ready drops only while it is full,
// and the whole pipeline holds in that cycle.
module fixed_point_mul_div_unit (
  input  logic       clk,
  input  logic       rst_n,
  fpmd_in_if.sink    in_ch,
  fpmd_out_if.source out_ch
);
  import fpmd_pkg::*;

  logic       en;
  div_stage_t stg [0:DIV_STAGES];
  out_item_t  out_item;

  fpmd_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_ch.valid),
    .in_command   (in_ch.command),
    .in_operand_a (in_ch.operand_a),
    .in_operand_b (in_ch.operand_b),
    .s_out        (stg[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    fpmd_div_stage u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .s_in  (stg[g]),
      .s_out (stg[g+1])
    );
  end

  fpmd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_in      (stg[DIV_STAGES]),
    .en        (en),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign in_ch.ready           = en;
  assign out_ch.result_value   = out_item.result_value;
  assign out_ch.divide_by_zero = out_item.divide_by_zero;

endmodule

@@ rtl/fpmd_checker.sv @@
// Port-level checks for the fixed-point multiply/divide unit, bound to the top level
`include "fixed_point_mul_div_unit_defines.svh"

module fpmd_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input fpmd_pkg::field_t out_result_value,
  input logic             out_divide_by_zero
);
  import fpmd_pkg::*;

  logic [FIELD_BITS:0] out_item;

  assign out_item = {out_result_value, out_divide_by_zero};

  // a stalled result stays offered
  `FPMD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // a stalled result keeps its value
  `FPMD_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_item))

  // a zero divisor always reports a zero result
  `FPMD_ASSERT_IMPLY(a_dz_zero, clk, rst_n, out_valid && out_divide_by_zero, out_result_value == '0)

  // a taken result empties the skid entry, so input ready returns
  `FPMD_ASSERT_NEXT(a_ready_back, clk, rst_n, !in_ready && out_ready, in_ready)

endmodule

bind fixed_point_mul_div_unit fpmd_checker u_fpmd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_result_value   (out_ch.result_value),
  .out_divide_by_zero (out_ch.divide_by_zero)
);

@@ tb/sv/fixed_point_mul_div_unit_chk.sv @@
`timescale 1ns / 1ps
// Result checker for the fixed-point multiply/divide unit: predicts each request and compares
module fixed_point_mul_div_unit_chk (
  input  logic clk,
  input  logic rst_n,
  fpmd_in_if   in_ch,
  fpmd_out_if  out_ch,
  output int   open_results,
  output int   mismatches
);
  import fpmd_pkg::*;

  // operands come from at most 32 bits of their fields
  localparam int OPND_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;

  out_item_t awaited_q[$];
  out_item_t want;
  int        err_cnt = 0;

  assign mismatches = err_cnt;

  function automatic logic signed [63:0] take_operand(input field_t f);
    logic signed [OPND_BITS-1:0] t;
    t = f[OPND_BITS-1:0];
    return t;
  endfunction

  function automatic field_t wrap_to_word(input logic signed [63:0] v);
    logic signed [WORD_BITS-1:0] w;
    logic signed [63:0]          x;
    w = v[WORD_BITS-1:0];
    x = w;
    return x[FIELD_BITS-1:0];
  endfunction

  function automatic out_item_t mul_div_result(input cmd_t cmd, input field_t fa,
                                               input field_t fb);
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] prod;
    logic [63:0]        mag_a;
    logic [63:0]        mag_b;
    logic [63:0]        quo;
    out_item_t          r;
    a = take_operand(fa);
    b = take_operand(fb);
    r.result_value   = '0;
    r.divide_by_zero = 1'b0;
    if (cmd == CMD_MUL) begin
      // floor of the scaled product: arithmetic shift of the full product
      prod = a * b;
      r.result_value = wrap_to_word(prod >>> FRAC_BITS);
    end else if (b == 0) begin
      r.divide_by_zero = 1'b1;
    end else begin
      // divide magnitudes, then restore the sign: truncates toward zero
      mag_a = a[63] ? -a : a;
      mag_b = b[63] ? -b : b;
      quo = (mag_a << FRAC_BITS) / mag_b;
      if (a[63] != b[63]) quo = -quo;
      r.result_value = wrap_to_word(quo);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      open_results <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        awaited_q.push_back(mul_div_result(in_ch.command, in_ch.operand_a, in_ch.operand_b));
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_q.size() == 0) begin
          $error("result with no request pending: result_value %h divide_by_zero %b",
                 out_ch.result_value, out_ch.divide_by_zero);
          err_cnt++;
        end else begin
          want = awaited_q.pop_front();
          if (out_ch.result_value !== want.result_value) begin
            $error("result_value: expected %h, got %h", want.result_value,
                   out_ch.result_value);
            err_cnt++;
          end
          if (out_ch.divide_by_zero !== want.divide_by_zero) begin
            $error("divide_by_zero: expected %b, got %b", want.divide_by_zero,
                   out_ch.divide_by_zero);
            err_cnt++;
          end
        end
      end
      open_results <= awaited_q.size();
    end
  end

endmodule

@@ tb/sv/fixed_point_mul_div_unit_tb.sv @@
`timescale 1ns / 1ps
// Top of the fixed-point multiply/divide unit testbench: clock, reset, requests and verdict
module fixed_point_mul_div_unit_tb;
  import fpmd_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_REQS   = 390;

  localparam field_t V_MAX     = 32'sh7FFF_FFFF;
  localparam field_t V_MIN     = 32'sh8000_0000;
  localparam field_t V_ONE     = 32'sh0001_0000;
  localparam field_t V_NEG_ONE = 32'shFFFF_0000;
  localparam field_t V_M1      = 32'shFFFF_FFFF;
  localparam field_t V_ALT_A   = 32'shAAAA_AAAA;
  localparam field_t V_ALT_5   = 32'sh5555_5555;

  logic clk;
  logic rst_n;
  int   open_results;
  int   mismatches;
  int   idle_pct    = 0;
  int   stall_pct   = 0;
  int   holds_asked = 0;
  int   holds_done  = 0;
  int   cycles      = 0;

  fpmd_in_if  in_ch ();
  fpmd_out_if out_ch ();

  fixed_point_mul_div_unit i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  fixed_point_mul_div_unit_chk i_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .open_results(open_results),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("fixed_point_mul_div_unit regression: fail");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off whenever one is asked
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_req(input cmd_t c, input field_t a, input field_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= c;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // drop valid and hold until every pending result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
  endtask

  function automatic field_t pick_operand();
    field_t corners[7];
    corners = '{V_MAX, V_MIN, V_ONE, V_NEG_ONE, V_M1, 32'sd1, 32'sd0};
    case ($urandom_range(9))
      0:       return corners[$urandom_range(6)];
      1, 2, 3: return field_t'($urandom_range(2097151)) - 32'sd1048576;
      default: return field_t'($urandom);
    endcase
  endfunction

  task automatic random_reqs(input int n);
    cmd_t   c;
    field_t a;
    field_t b;
    repeat (n) begin
      c = $urandom_range(1) ? CMD_DIV : CMD_MUL;
      a = pick_operand();
      b = ($urandom_range(19) == 0) ? field_t'(0) : pick_operand();
      send_req(c, a, b);
    end
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.command   <= CMD_MUL;
    in_ch.operand_a <= '0;
    in_ch.operand_b <= '0;
    rst_n           <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // multiply corners, rounding toward minus infinity included
    send_req(CMD_MUL, 32'sd0, 32'sd0);
    send_req(CMD_MUL, V_MAX, V_MAX);
    send_req(CMD_MUL, V_MIN, V_MIN);
    send_req(CMD_MUL, V_MIN, V_MAX);
    send_req(CMD_MUL, V_M1, V_M1);
    send_req(CMD_MUL, V_M1, 32'sd1);
    send_req(CMD_MUL, V_ONE, V_ONE);
    send_req(CMD_MUL, V_NEG_ONE, 32'sh0001_8000);
    send_req(CMD_MUL, V_MAX, 32'sd0);
    send_req(CMD_MUL, V_ALT_A, V_ALT_5);
    // divide corners: zero divisor, wrap of the most negative value, truncation
    send_req(CMD_DIV, V_ONE, 32'sd0);
    send_req(CMD_DIV, V_MIN, 32'sd0);
    send_req(CMD_DIV, 32'sd0, 32'sd0);
    send_req(CMD_DIV, V_MIN, V_M1);
    send_req(CMD_DIV, V_MIN, V_NEG_ONE);
    send_req(CMD_DIV, V_MAX, 32'sd1);
    send_req(CMD_DIV, 32'sd1, V_MAX);
    send_req(CMD_DIV, -32'sd7, 32'sd2);
    send_req(CMD_DIV, 32'sd7, -32'sd2);
    send_req(CMD_DIV, V_MAX, V_MIN);
    send_req(CMD_DIV, V_MIN, V_MIN);
    send_req(CMD_DIV, V_ALT_5, V_ALT_A);
    send_req(CMD_DIV, V_NEG_ONE, V_ONE);
    drain();

    idle_pct  = 0;
    stall_pct = 0;
    random_reqs(PHASE_REQS);
    drain();

    idle_pct  = 78;
    stall_pct = 0;
    random_reqs(PHASE_REQS);
    drain();

    idle_pct  = 0;
    stall_pct = 78;
    random_reqs(PHASE_REQS);
    drain();

    idle_pct  = 22;
    stall_pct = 22;
    random_reqs(PHASE_REQS);
    drain();

    // back-pressure: result side holds off while requests keep coming
    idle_pct  = 0;
    stall_pct = 0;
    holds_asked++;
    random_reqs(100);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && open_results == 0) begin
      $display("fixed_point_mul_div_unit regression: pass");
    end else begin
      $display("fixed_point_mul_div_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/fpmd_pkg.sv
rtl/fpmd_in_if.sv
rtl/fpmd_out_if.sv
rtl/fpmd_prep.sv
rtl/fpmd_div_stage.sv
rtl/fpmd_out_stage.sv
rtl/fixed_point_mul_div_unit.sv
rtl/fpmd_checker.sv
tb/sv/fixed_point_mul_div_unit_chk.sv
tb/sv/fixed_point_mul_div_unit_tb.sv
